// File: hw/rtl/gsma_pkg.sv
// shared types and constants for the gated sensor moving average
`timescale 1ns / 1ps

package gsma_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned SUM_W = 22;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_SAMPLE_PERIOD = 2'd0;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic signed [DATA_W-1:0] AVERAGE_RESET = 16'sd2500;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } gsma_state_t;

endpackage

// File: hw/rtl/gsma_window.sv
// ring store of the accepted readings, one write and one registered read port
`timescale 1ns / 1ps

module gsma_window #(
    parameter int unsigned DEPTH = 30,
    parameter int unsigned SLOT_W = 5
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [SLOT_W-1:0]             rd_slot,
    output logic signed [gsma_pkg::DATA_W-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [SLOT_W-1:0]             wr_slot,
    input  logic signed [gsma_pkg::DATA_W-1:0] wr_data
);
    import gsma_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/gsma_div.sv
// bit-serial restoring divider, signed sum by unsigned fill count
`timescale 1ns / 1ps

module gsma_div #(
    parameter int unsigned CNT_W = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gsma_pkg::SUM_W-1:0]   dividend,
    input  logic [CNT_W-1:0]                    divisor,
    output logic                                done,
    output logic signed [gsma_pkg::DATA_W-1:0]  quotient
);
    import gsma_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [SUM_W-1:0]  quo_signed;

    // one quotient bit per cycle, msb first
    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next = '0;
            dsr_next = divisor;
            neg_next = dividend[SUM_W-1];
            step_next = STEP_W'(SUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // quotient magnitude always fits the reading width, truncation toward zero
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = quo_signed[DATA_W-1:0];
    assign done = done_reg;

endmodule

// File: hw/rtl/gated_sensor_moving_average.sv
// top level of the gated sensor moving average: gate, ring, running sum and serial divide
//
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     time_ms, reading
// out       source     out_valid / out_ready   average, taken
// apb       sink       psel/penable/pready     paddr, pwdata, prdata (sample period)
//
// a gated-off beat goes from acceptance straight to the deliver state
// a taken beat passes through update, divide and deliver after acceptance
// the serial divider sets how long divide lasts: 22 quotient bits, one a cycle, then a done cycle
// one beat in flight; out holds its beat in a register, the next in beat is taken meanwhile
// rst_n clears gate, sum, counts and average (2500); ring contents stay unknown
`timescale 1ns / 1ps

module gated_sensor_moving_average #(
    parameter int unsigned WINDOW = 30
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input beats
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [gsma_pkg::TIME_W-1:0]             time_ms,
    input  logic signed [gsma_pkg::DATA_W-1:0]      reading,
    // result beats
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [gsma_pkg::DATA_W-1:0]      average,
    output logic                                    taken,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [gsma_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [gsma_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [gsma_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import gsma_pkg::*;

    // fill count must reach WINDOW itself
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WINDOW - 1);

    gsma_state_t state_reg, state_next;

    // configuration
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                cfg_write;

    // gate state
    logic              have_reg, have_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [TIME_W-1:0] elapsed;
    logic              gate_open;
    logic              in_beat;

    // window state
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         slot_reg, slot_next;
    logic signed [DATA_W-1:0] avg_reg, avg_next;
    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic                     took_reg, took_next;
    logic                     ring_full;

    // ring and divider hookup
    logic                     win_rd_en;
    logic                     win_wr_en;
    logic signed [DATA_W-1:0] win_old;
    logic                     div_start;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quotient;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_avg_reg, out_avg_next;
    logic                     out_taken_reg, out_taken_next;

    // apb: single register, writes land on the access phase
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_SAMPLE_PERIOD);
    assign prdata = (paddr == ADDR_SAMPLE_PERIOD) ? APB_DATA_W'(period_reg) : '0;
    assign period_next = cfg_write ? pwdata[PERIOD_W-1:0] : period_reg;

    // elapsed time wraps modulo 2^32, first beat after reset always passes
    assign elapsed = time_ms - last_time_reg;
    assign gate_open = !have_reg || (elapsed >= TIME_W'(period_reg));
    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat = in_valid && in_ready;
    assign ring_full = (fill_reg == WINDOW_CNT);

    // old entry is fetched on acceptance, ready for the update cycle
    assign win_rd_en = in_beat && gate_open;

    always_comb
    begin
        state_next = state_reg;
        have_next = have_reg;
        last_time_next = last_time_reg;
        sum_next = sum_reg;
        fill_next = fill_reg;
        slot_next = slot_reg;
        avg_next = avg_reg;
        sample_next = sample_reg;
        took_next = took_reg;
        out_valid_next = out_valid_reg;
        out_avg_next = out_avg_reg;
        out_taken_next = out_taken_reg;
        win_wr_en = 1'b0;
        div_start = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    sample_next = reading;
                    took_next = gate_open;
                    if (gate_open)
                    begin
                        have_next = 1'b1;
                        last_time_next = time_ms;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_UPDATE:
            begin
                // drop the oldest entry only once the ring has wrapped
                sum_next = sum_reg + SUM_W'(sample_reg)
                           - (ring_full ? SUM_W'(win_old) : SUM_W'(0));
                if (!ring_full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                win_wr_en = 1'b1;
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                div_start = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next = div_quotient;
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                // result register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next = avg_reg;
                    out_taken_next = took_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            period_reg <= PERIOD_RESET;
            have_reg <= 1'b0;
            last_time_reg <= '0;
            sum_reg <= '0;
            fill_reg <= '0;
            slot_reg <= '0;
            avg_reg <= AVERAGE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            period_reg <= period_next;
            have_reg <= have_next;
            last_time_reg <= last_time_next;
            sum_reg <= sum_next;
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            avg_reg <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        took_reg <= took_next;
        out_avg_reg <= out_avg_next;
        out_taken_reg <= out_taken_next;
    end

    gsma_window #(
        .DEPTH  (WINDOW),
        .SLOT_W (CNT_W)
    ) u_window (
        .clk     (clk),
        .rd_en   (win_rd_en),
        .rd_slot (slot_reg),
        .rd_data (win_old),
        .wr_en   (win_wr_en),
        .wr_slot (slot_reg),
        .wr_data (sample_reg)
    );

    // divisor is the fill count after this beat, never zero
    gsma_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid = out_valid_reg;
    assign average = out_avg_reg;
    assign taken = out_taken_reg;

endmodule

// File: verif/moving_average_checker.sv
// checker for the gated sensor moving average: predicts every result beat and compares
`timescale 1ns / 1ps

module moving_average_checker #(
    parameter int unsigned WINDOW = 30
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [gsma_pkg::TIME_W-1:0]             time_ms,
    input  logic signed [gsma_pkg::DATA_W-1:0]      reading,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [gsma_pkg::DATA_W-1:0]      average,
    input  logic                                    taken,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [gsma_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [gsma_pkg::APB_DATA_W-1:0]         pwdata,
    input  logic [gsma_pkg::APB_DATA_W-1:0]         prdata,
    input  logic                                    pready,
    output int                                      fail_count,
    output int                                      outstanding
);

    import gsma_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic              taken;
    } average_beat_t;

    average_beat_t              expected_beats[$];

    // shadow of the block's state
    logic [PERIOD_W-1:0]        period_reg;
    logic signed [DATA_W-1:0]   ring[WINDOW];
    logic signed [SUM_W-1:0]    window_sum;
    int unsigned                write_idx;
    int unsigned                fill_n;
    logic                       sampled;
    logic [TIME_W-1:0]          last_time;
    logic signed [DATA_W-1:0]   average_hold;

    task automatic admit_reading(input logic [TIME_W-1:0] now,
                                 input logic signed [DATA_W-1:0] value,
                                 output average_beat_t beat);
        logic [TIME_W-1:0] elapsed;
        int                quotient;
        elapsed = now - last_time;
        beat.taken = 1'b0;
        if (!sampled || elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_reg}) begin
            beat.taken = 1'b1;
            sampled = 1'b1;
            last_time = now;
            if (fill_n < WINDOW)
                fill_n++;
            else
                window_sum = window_sum - ring[write_idx];
            ring[write_idx] = value;
            window_sum = window_sum + value;
            write_idx = (write_idx + 1 >= WINDOW) ? 0 : write_idx + 1;
            quotient = int'(window_sum) / int'(fill_n);
            average_hold = quotient[DATA_W-1:0];
        end
        beat.average = average_hold;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        average_beat_t predicted;
        average_beat_t oldest;
        if (!rst_n)
        begin
            period_reg = PERIOD_RESET;
            foreach (ring[i])
                ring[i] = '0;
            window_sum = '0;
            write_idx = 0;
            fill_n = 0;
            sampled = 1'b0;
            last_time = '0;
            average_hold = AVERAGE_RESET;
            expected_beats.delete();
            fail_count = 0;
        end
        else
        begin
            // register access
            if (psel && penable && pready && paddr == ADDR_SAMPLE_PERIOD)
            begin
                if (pwrite)
                    period_reg = pwdata[PERIOD_W-1:0];
                else if (prdata !== {{(APB_DATA_W-PERIOD_W){1'b0}}, period_reg})
                begin
                    $display("%0t: period readback mismatch, expected %0d, actual %0d",
                             $time, period_reg, prdata);
                    fail_count++;
                end
            end
            // result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0d/%0b",
                             $time, average, taken);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_beats.pop_front();
                    if (average !== oldest.average)
                    begin
                        $display("%0t: average mismatch, expected %0d, actual %0d",
                                 $time, $signed(oldest.average), average);
                        fail_count++;
                    end
                    if (taken !== oldest.taken)
                    begin
                        $display("%0t: taken mismatch, expected %0b, actual %0b",
                                 $time, oldest.taken, taken);
                        fail_count++;
                    end
                end
            end
            // input beat
            if (in_valid && in_ready)
            begin
                admit_reading(time_ms, reading, predicted);
                expected_beats.push_back(predicted);
            end
        end
        outstanding = expected_beats.size();
    end

endmodule

// File: verif/gated_sensor_moving_average_test.sv
// top of the moving average testbench: clock, reset, beat stimulus, configuration and verdict
`timescale 1ns / 1ps

module gated_sensor_moving_average_test;

    import gsma_pkg::*;

    localparam int unsigned WINDOW = 30;
    // no beat moves for this long and the run is declared hung; the slowest
    // legitimate quiet stretch is the long receiver hold-off plus one beat
    localparam int QUIET_LIMIT = 2000;
    // cycles left after the last expected beat, well beyond what a taken beat needs
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_BEATS = 240;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [TIME_W-1:0]      time_ms;
    logic signed [DATA_W-1:0] reading;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [DATA_W-1:0] average;
    logic                   taken;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     fail_count;
    int                     outstanding;
    int                     quiet_cycles = 0;

    // receiver behaviour, steered by the stimulus process
    int                     stall_pct = 0;
    bit                     hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gated_sensor_moving_average #(
        .WINDOW (WINDOW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .time_ms   (time_ms),
        .reading   (reading),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average),
        .taken     (taken),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    moving_average_checker #(
        .WINDOW (WINDOW)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .time_ms     (time_ms),
        .reading     (reading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .taken       (taken),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // hang detection: counts cycles in which no beat moves on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request so
    // the block backs up and has to refuse input beats
    initial
    begin
        int burst;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (burst) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input logic [TIME_W-1:0] stamp,
                             input logic signed [DATA_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b1;
        time_ms <= stamp;
        reading <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // one apb transfer to the sample period register; a read is checked by the checker
    task automatic apb_access(input logic write_en, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write_en;
        paddr <= ADDR_SAMPLE_PERIOD;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop offering, let every predicted beat come back, then let the divider run dry
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // reprogram only with the block idle, and read the value back
    task automatic set_period(input logic [PERIOD_W-1:0] period);
        drain_results();
        apb_access(1'b1, {{(APB_DATA_W-PERIOD_W){1'b0}}, period});
        apb_access(1'b0, '0);
    endtask

    initial
    begin
        logic [TIME_W-1:0]        clock_ms;
        logic [PERIOD_W-1:0]      period_now;
        logic [TIME_W-1:0]        advance;
        logic signed [DATA_W-1:0] value;
        int                       gap_pct;
        int                       bias_pct;
        int                       choice;
        bit                       low_side;

        rst_n = 1'b0;
        in_valid = 1'b0;
        time_ms = '0;
        reading = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_SAMPLE_PERIOD;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the period must read back as 1000
        apb_access(1'b0, '0);

        // ---- directed part ----
        // first beat after reset is always taken, and we start just short of the
        // tick wrap so the gate has to cope with the counter rolling over
        clock_ms = 32'hFFFF_FE00;
        send_beat(clock_ms, 16'sh8000);
        // one tick short of the period: gated off
        send_beat(clock_ms + 32'd999, 16'sh7FFF);
        // exactly the period, across the wrap: taken, average truncates to zero
        clock_ms = clock_ms + 32'd1000;
        send_beat(clock_ms, 16'sh7FFF);
        // same stamp again: gated off
        send_beat(clock_ms, 16'sh0000);
        clock_ms = clock_ms + 32'd1500;
        send_beat(clock_ms, -16'sd1);
        // negative sum that does not divide evenly, truncation toward zero
        clock_ms = clock_ms + 32'd1000;
        send_beat(clock_ms, -16'sd7);

        // period of zero: the gate never blocks, even with a frozen time stamp
        set_period(16'd0);
        period_now = 16'd0;
        repeat (4)
            send_beat(clock_ms, 16'($urandom()));

        // widest period
        set_period(16'hFFFF);
        period_now = 16'hFFFF;
        send_beat(clock_ms + 32'd65534, 16'($urandom()));
        clock_ms = clock_ms + 32'd65535;
        send_beat(clock_ms, 16'($urandom()));
        // largest possible elapsed time
        clock_ms = clock_ms + 32'hFFFF_FFFF;
        send_beat(clock_ms, 16'($urandom()));

        // smallest nonzero period
        set_period(16'd1);
        period_now = 16'd1;
        repeat (11)
        begin
            clock_ms = clock_ms + 32'd1;
            send_beat(clock_ms, 16'($urandom()));
        end

        // ---- random part, in phases of differing period and pressure ----
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    period_now = 16'd1;
                    gap_pct = 20; bias_pct = 10;
                end
                1:
                begin
                    period_now = 16'($urandom_range(2, 100));
                    gap_pct = 0; bias_pct = 60;
                end
                2:
                begin
                    period_now = 16'hFFFF;
                    gap_pct = 30; bias_pct = 10;
                end
                3:
                begin
                    period_now = 16'($urandom_range(1, 65535));
                    gap_pct = 10; bias_pct = 80;
                end
                4:
                begin
                    period_now = 16'd0;
                    gap_pct = 25; bias_pct = 10;
                end
                default:
                begin
                    period_now = 16'($urandom_range(1, 2000));
                    gap_pct = 0; bias_pct = 20;
                end
            endcase
            set_period(period_now);
            // receiver stall rate per phase; the closing phase runs with no idling at all
            case (phase)
                0: stall_pct = 5;
                1: stall_pct = 8;
                2: stall_pct = 0;
                3: stall_pct = 3;
                4: stall_pct = 10;
                default: stall_pct = 0;
            endcase
            // long hold-off while the sender keeps offering back to back
            if (phase == 1)
                hold_req = 1'b1;
            low_side = $urandom_range(0, 1);

            repeat (PHASE_BEATS)
            begin
                // spacing of time stamps around the period, so the gate sees
                // both sides of its threshold as well as wild jumps
                choice = $urandom_range(0, 9);
                case (choice)
                    0, 1, 2, 3: advance = period_now + $urandom_range(0, 3);
                    4: advance = (period_now == 0) ? 32'd0 : period_now - 32'd1;
                    5: advance = period_now;
                    6: advance = $urandom_range(0, period_now);
                    7: advance = $urandom();
                    8: advance = 32'd0;
                    default: advance = period_now + $urandom_range(0, 2 * period_now + 10);
                endcase
                clock_ms = clock_ms + advance;

                // runs of one extreme push the window average to its limits
                if ($urandom_range(0, 99) < bias_pct)
                    value = low_side ? 16'sh8000 : 16'sh7FFF;
                else if ($urandom_range(0, 15) == 0)
                    value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                else
                    value = 16'($urandom());

                if ($urandom_range(0, 99) < gap_pct)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat ($urandom_range(0, 14)) @(negedge clk);
                end
                send_beat(clock_ms, value);
            end
        end

        drain_results();
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
